// ----- rtl/clft_pkg.sv -----
// shared types and constants of the csv line and field tokenizer
package clft_pkg;

  localparam int unsigned LINE_LENGTH_LIMIT = 4095;

  localparam int unsigned CAP_W   = 12;
  localparam int unsigned FIELD_W = 4;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 4;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  localparam logic [CAP_W-1:0]   LINE_CAPACITY_RST = 12'd255;
  localparam logic [FIELD_W-1:0] FIELD_LIMIT_RST   = 4'd2;

  typedef enum logic [INDEX_W-1:0] {
    REG_LINE_CAPACITY = 4'd0,
    REG_FIELD_LIMIT   = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ITEM_CONTENT   = 2'd0,
    ITEM_FIELD_END = 2'd1,
    ITEM_LINE_END  = 2'd2
  } item_type_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CAP_W-1:0]   line_capacity;
    logic [FIELD_W-1:0] field_limit;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    item_type_e         item_type;
    logic [BYTE_W-1:0]  out_byte;
    logic [FIELD_W-1:0] field_number;
    logic [LINE_W-1:0]  line_number;
    logic               field_over_limit;
    logic               line_truncated;
  } result_t;

endpackage

// ----- rtl/clft_if.sv -----
// channel interfaces of the csv line and field tokenizer
interface clft_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, kind, byte_value, input ready);
  modport sink (input valid, kind, byte_value, output ready);
endinterface

interface clft_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_type;
  logic [7:0]  out_byte;
  logic [3:0]  field_number;
  logic [15:0] line_number;
  logic        field_over_limit;
  logic        line_truncated;

  modport source (output valid, item_type, out_byte, field_number, line_number,
                  field_over_limit, line_truncated, input ready);
  modport sink (input valid, item_type, out_byte, field_number, line_number,
                field_over_limit, line_truncated, output ready);
endinterface

interface clft_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/clft_cfg_regs.sv -----
// configuration registers: line capacity and field limit
module clft_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  clft_cfg_if.sink       cfg_i,
  output clft_pkg::cfg_t cfg_o
);

  clft_pkg::cfg_t cfg_q, cfg_d;
  logic           wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      if (cfg_i.index == clft_pkg::REG_LINE_CAPACITY) begin
        cfg_d.line_capacity = cfg_i.data;
      end else if (cfg_i.index == clft_pkg::REG_FIELD_LIMIT) begin
        cfg_d.field_limit = cfg_i.data[clft_pkg::FIELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_capacity <= clft_pkg::LINE_CAPACITY_RST;
      cfg_q.field_limit   <= clft_pkg::FIELD_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/clft_in_stage.sv -----
// input register holding one accepted byte transaction
module clft_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  clft_in_if.sink            in_i,
  input  logic               take_i,
  output logic               valid_o,
  output clft_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  clft_pkg::in_item_t item_q;
  logic               acc;

  assign in_i.ready = !valid_q || take_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (acc) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q.kind       <= in_i.kind;
      item_q.byte_value <= in_i.byte_value;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/clft_parser.sv -----
// line and field state with the per-byte tokenizing logic
module clft_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clft_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  input  clft_pkg::in_item_t item_i,
  input  logic               free_i,
  output logic               take_o,
  output logic               load_o,
  output clft_pkg::result_t  res_o
);

  logic                           quoted_q, quoted_d;
  logic                           closed_q, closed_d;
  logic                           pending_q, pending_d;
  logic                           trunc_q, trunc_d;
  logic [clft_pkg::CAP_W-1:0]     raw_q, raw_d;
  logic [clft_pkg::FIELD_W-1:0]   field_q, field_d;
  logic [clft_pkg::LINE_W-1:0]    line_q, line_d;
  logic [clft_pkg::CAP_W-1:0]     cap;
  logic                           is_eol;
  logic                           res_valid;
  clft_pkg::item_type_e           res_type;
  logic [clft_pkg::BYTE_W-1:0]    res_byte;

  assign cap = (32'(cfg_i.line_capacity) > clft_pkg::LINE_LENGTH_LIMIT)
             ? clft_pkg::CAP_W'(clft_pkg::LINE_LENGTH_LIMIT) : cfg_i.line_capacity;

  assign is_eol = (item_i.kind == clft_pkg::KIND_END)
               || (item_i.byte_value == clft_pkg::CH_LF)
               || (item_i.byte_value == clft_pkg::CH_CR);

  always_comb begin
    quoted_d  = quoted_q;
    closed_d  = closed_q;
    pending_d = pending_q;
    trunc_d   = trunc_q;
    raw_d     = raw_q;
    field_d   = field_q;
    line_d    = line_q;
    res_valid = 1'b0;
    res_type  = clft_pkg::ITEM_CONTENT;
    res_byte  = '0;
    if (is_eol) begin
      if (pending_q) begin
        res_valid = 1'b1;
        res_type  = clft_pkg::ITEM_LINE_END;
        quoted_d  = 1'b0;
        closed_d  = 1'b0;
        pending_d = 1'b0;
        trunc_d   = 1'b0;
        raw_d     = '0;
        field_d   = '0;
        line_d    = line_q + 1'b1;
      end
    end else begin
      pending_d = 1'b1;
      if (raw_q >= cap) begin
        trunc_d = 1'b1;
      end else begin
        raw_d = raw_q + 1'b1;
        if (item_i.byte_value == clft_pkg::CH_QUOTE) begin
          closed_d = quoted_q;
          quoted_d = !quoted_q;
          if (closed_q) begin
            res_valid = 1'b1;
            res_byte  = item_i.byte_value;
          end
        end else begin
          closed_d = 1'b0;
          res_valid = 1'b1;
          if (item_i.byte_value == clft_pkg::CH_COMMA && !quoted_q) begin
            res_type = clft_pkg::ITEM_FIELD_END;
            if (field_q != clft_pkg::FIELD_MAX) begin
              field_d = field_q + 1'b1;
            end
          end else begin
            res_byte = item_i.byte_value;
          end
        end
      end
    end
  end

  // an item with a result waits for room in the output register
  assign take_o = valid_i && (!res_valid || free_i);
  assign load_o = take_o && res_valid;

  always_comb begin
    res_o.item_type        = res_type;
    res_o.out_byte         = res_byte;
    res_o.field_number     = field_q;
    res_o.line_number      = line_q;
    res_o.field_over_limit = field_q >= cfg_i.field_limit;
    res_o.line_truncated   = trunc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      closed_q  <= 1'b0;
      pending_q <= 1'b0;
      trunc_q   <= 1'b0;
      raw_q     <= '0;
      field_q   <= '0;
      line_q    <= '0;
    end else if (take_o) begin
      quoted_q  <= quoted_d;
      closed_q  <= closed_d;
      pending_q <= pending_d;
      trunc_q   <= trunc_d;
      raw_q     <= raw_d;
      field_q   <= field_d;
      line_q    <= line_d;
    end
  end

endmodule

// ----- rtl/clft_out_stage.sv -----
// output register holding one result transaction
module clft_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  clft_pkg::result_t res_i,
  output logic              free_o,
  clft_out_if.source        out_o
);

  logic              valid_q, valid_d;
  clft_pkg::result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.item_type        = res_q.item_type;
  assign out_o.out_byte         = res_q.out_byte;
  assign out_o.field_number     = res_q.field_number;
  assign out_o.line_number      = res_q.line_number;
  assign out_o.field_over_limit = res_q.field_over_limit;
  assign out_o.line_truncated   = res_q.line_truncated;

endmodule

// ----- rtl/csv_line_field_tokenizer.sv -----
// Splits a stream of CSV text bytes into content characters, end-of-field and
// end-of-line transactions tagged with field and line numbers. One byte
// transaction is taken every cycle as long as the result side keeps up; a
// byte passes an input register, the tokenizing logic and an output register,
// and its result waits in the output register until it is taken. The rate
// is set only by the output register: a waiting result stalls the next byte
// that produces one. Configuration registers: index 0 line capacity, index 1
// field limit; write them only while no byte is in flight.
module csv_line_field_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  clft_cfg_if.sink    cfg_i,
  clft_in_if.sink     in_i,
  clft_out_if.source  out_o
);

  clft_pkg::cfg_t     cfg;
  clft_pkg::in_item_t item;
  clft_pkg::result_t  res;
  logic               item_valid;
  logic               take;
  logic               load;
  logic               free;

  clft_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  clft_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  clft_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (item_valid),
    .item_i  (item),
    .free_i  (free),
    .take_o  (take),
    .load_o  (load),
    .res_o   (res)
  );

  clft_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> free)
    else $error("result loaded while output register busy");

  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !take |=> item_valid && $stable(item))
    else $error("held input transaction lost or changed");

  a_marker_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item_type != clft_pkg::ITEM_CONTENT |->
      out_o.out_byte == '0 && (out_o.item_type == clft_pkg::ITEM_FIELD_END ||
                               out_o.item_type == clft_pkg::ITEM_LINE_END))
    else $error("marker transaction with bad type or nonzero byte");
`endif

endmodule
